// ----- hdl/hcl_pkg.sv -----
// hcl_pkg: shared types, constants and the header-name lookup for the
// Content-Length scanner. No dependencies.
`default_nettype none

package hcl_pkg;

  // width of the parsed value; values above 2^VALUE_BITS - 1 are malformed
  localparam int unsigned VALUE_BITS = 31;
  // width of the length field on the result port
  localparam int unsigned OUT_BITS   = 31;

  localparam logic [4:0] NAME_LEN  = 5'd15;
  localparam logic [4:0] MIN_LEN   = 5'd17;
  localparam logic [4:0] POS_MAX   = 5'd31;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_BAD    = 2'd2
  } status_t;

  // scanner state carried from byte to byte
  typedef struct packed {
    logic [4:0]            pos;
    logic                  prefix;
    logic [7:0]            held_char;
    logic                  held_valid;
    logic [VALUE_BITS-1:0] line_value;
    logic                  line_bad;
    logic                  found;
    logic [VALUE_BITS-1:0] stored_value;
    logic                  err;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    pos:          5'd0,
    prefix:       1'b1,
    held_char:    8'h00,
    held_valid:   1'b0,
    line_value:   '0,
    line_bad:     1'b0,
    found:        1'b0,
    stored_value: '0,
    err:          1'b0
  };

  // expected character of "Content-Length:" at a given line position
  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h4C; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      4'd14:   c = 8'h3A; // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/http_content_length_scan_core.sv -----
// http_content_length_scan_core: top level of the Content-Length scanner.
// Depends on hcl_pkg and hcl_scan_step.
`default_nettype none

// Takes one header byte per clock while in_stall is low and keeps the scan state in
// registers; the byte marked last yields one result word (length and status) in the
// result register on the next cycle, after which the scan state is back at reset
// for the next request. Throughput is one byte per cycle while not stalled; the
// result comes from the single state-update step (a 35-bit multiply-by-ten-and-add
// and compare). in_stall is high only while a result word is waiting and out_stall
// holds it.
module http_content_length_scan_core
  import hcl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          in_byte_req,
  input  wire logic                in_last,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [30:0]              out_length_value,
  output logic [1:0]               out_status
);

  scan_state_t       scan_r;
  scan_state_t       scan_step_nxt;
  scan_state_t       scan_nxt;
  logic              in_acc;
  logic              out_load;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [OUT_BITS-1:0] out_len_r;
  logic [OUT_BITS-1:0] out_len_nxt;
  status_t           out_status_r;
  status_t           out_status_nxt;
  logic [VALUE_BITS+OUT_BITS-1:0] stored_ext;

  // handshake
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign out_load = !out_valid_r || !out_stall;

  // per-byte scan logic
  hcl_scan_step u_step (
    .cur     (scan_r),
    .byte_in (in_byte_req),
    .nxt     (scan_step_nxt)
  );

  // result word from the post-scan state
  always_comb begin
    stored_ext = {{OUT_BITS{1'b0}}, scan_step_nxt.stored_value};
    if (scan_step_nxt.err) begin
      out_status_nxt = ST_BAD;
      out_len_nxt    = '0;
    end else if (scan_step_nxt.found) begin
      out_status_nxt = ST_OK;
      out_len_nxt    = stored_ext[OUT_BITS-1:0];
    end else begin
      out_status_nxt = ST_ABSENT;
      out_len_nxt    = '0;
    end
  end

  // state next value: back to reset after the last byte
  always_comb begin
    scan_nxt = scan_r;
    if (in_acc) begin
      scan_nxt = in_last ? SCAN_RESET : scan_step_nxt;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = in_acc && in_last;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= SCAN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load && in_acc && in_last) begin
      out_len_r    <= out_len_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_length_value = out_len_r;
  assign out_status       = out_status_r;

  // checks
  a_last_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> out_valid)
    else $error("accepted last byte did not produce a result word");

  a_len_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_length_value == '0)
    else $error("length nonzero on a result that is not ok");

  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=>
      (scan_r.pos == 5'd0) && !scan_r.found && !scan_r.err && scan_r.prefix)
    else $error("scan state not cleared after end of request");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result word");

endmodule

`default_nettype wire

// ----- hdl/hcl_scan_step.sv -----
// hcl_scan_step: next-state logic for one header byte of the scanner.
// Depends on hcl_pkg.
`default_nettype none

module hcl_scan_step
  import hcl_pkg::*;
(
  input  wire scan_state_t cur,
  input  wire logic [7:0]  byte_in,
  output scan_state_t      nxt
);

  localparam int unsigned PW = VALUE_BITS + 4;

  logic [PW-1:0] lv_ext;
  logic [PW-1:0] digit_ext;
  logic [PW-1:0] prod;
  logic          held_is_digit;
  logic          prod_ovf;
  logic          len_line;
  logic          len_bad;

  // value * 10 + digit for the held character, with overflow flag
  always_comb begin
    held_is_digit = (cur.held_char >= CHAR_ZERO) && (cur.held_char <= CHAR_NINE);
    lv_ext        = {4'b0000, cur.line_value};
    digit_ext     = {{VALUE_BITS{1'b0}}, 4'(cur.held_char - CHAR_ZERO)};
    prod          = (lv_ext << 3) + (lv_ext << 1) + digit_ext;
    prod_ovf      = (prod[PW-1:VALUE_BITS] != 4'b0000);
  end

  // line end classification
  always_comb begin
    len_line = cur.prefix && (cur.pos >= NAME_LEN);
    len_bad  = cur.line_bad || (cur.pos < MIN_LEN);
  end

  // byte update
  always_comb begin
    nxt = cur;
    if (byte_in == CHAR_LF) begin
      // close the line and record a length line
      if (len_line) begin
        if (len_bad) begin
          nxt.err = 1'b1;
        end else if (cur.found && (cur.stored_value != cur.line_value)) begin
          nxt.err = 1'b1;
        end else begin
          nxt.stored_value = cur.line_value;
          nxt.found        = 1'b1;
        end
      end
      nxt.pos        = 5'd0;
      nxt.prefix     = 1'b1;
      nxt.held_char  = 8'h00;
      nxt.held_valid = 1'b0;
      nxt.line_value = '0;
      nxt.line_bad   = 1'b0;
    end else if (byte_in != CHAR_SP) begin
      if (cur.pos < NAME_LEN) begin
        // name compare
        if (byte_in != name_char(cur.pos[3:0])) begin
          nxt.prefix = 1'b0;
        end
      end else if (cur.prefix) begin
        // commit the held character, hold the new one
        if (cur.held_valid) begin
          if (!held_is_digit || prod_ovf) begin
            nxt.line_bad = 1'b1;
          end else begin
            nxt.line_value = prod[VALUE_BITS-1:0];
          end
        end
        nxt.held_char  = byte_in;
        nxt.held_valid = 1'b1;
      end
      if (cur.pos < POS_MAX) begin
        nxt.pos = cur.pos + 5'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- test/tb_http_content_length_scan_core.sv -----
// tb_http_content_length_scan_core: self-checking bench for the Content-Length scanner.
// Feeds header bytes through the valid/stall input channel and checks every result word
// against a scan predictor or a typed row's own word. Depends on hcl_pkg and http_content_length_scan_core.
`timescale 1ns / 100ps

module tb_http_content_length_scan_core;
  import hcl_pkg::*;

  localparam int          WATCHDOG_LIMIT = 1000;
  localparam int          HOLD_CYCLES    = 120;
  localparam int          NAME_CHARS     = 15;
  localparam int          COL_MAX        = 31;
  localparam string       HDR_NAME       = "Content-Length:";
  localparam logic [7:0]  CH_LF          = 8'h0A;
  localparam logic [7:0]  CH_CR          = 8'h0D;
  localparam logic [7:0]  CH_SP          = 8'h20;
  localparam logic [7:0]  CH_ZERO        = 8'h30;
  localparam logic [7:0]  CH_NINE        = 8'h39;

  typedef struct packed {
    logic [30:0] len;
    status_t     st;
  } report_t;

  typedef struct {
    string   text;
    bit      typed;
    report_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic [7:0]  in_byte_req = 8'h00;
  logic        in_last     = 1'b0;
  logic        out_stall   = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [30:0] out_length_value;
  logic [1:0]  out_status;

  int send_idle_pct = 7;
  int stall_pct     = 63;
  int hold_asks     = 0;
  int mismatch_count = 0;
  int quiet_cycles  = 0;

  report_t  length_reports_due[$];
  report_t  head_report;
  dir_row_t directed_rows[$];

  // scan predictor state
  logic [4:0]      line_col;
  bit              name_ok;
  logic [7:0]      pend_ch;
  bit              pend_ok;
  longint unsigned acc;
  bit              acc_bad;
  bit              have_len;
  longint unsigned len_kept;
  bit              conflict;

  http_content_length_scan_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_req      (in_byte_req),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_length_value (out_length_value),
    .out_status       (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // predictor: line and request bookkeeping
  function automatic void new_line();
    line_col = '0;
    name_ok  = 1'b1;
    pend_ch  = '0;
    pend_ok  = 1'b0;
    acc      = 0;
    acc_bad  = 1'b0;
  endfunction

  function automatic void new_request();
    new_line();
    have_len = 1'b0;
    len_kept = 0;
    conflict = 1'b0;
  endfunction

  // fold one value character into the line's number
  function automatic void take_digit(input logic [7:0] c);
    longint unsigned d;
    longint unsigned top;
    top = (64'd1 << VALUE_BITS) - 1;
    if (c < CH_ZERO || c > CH_NINE) begin
      acc_bad = 1'b1;
    end else begin
      d = longint'(c - CH_ZERO);
      if (acc > (top - d) / 10) acc_bad = 1'b1;
      else acc = acc * 10 + d;
    end
  endfunction

  // a finished line counts only if it carried the full header name
  function automatic void close_line();
    if (name_ok && line_col >= NAME_CHARS) begin
      if (acc_bad || line_col < NAME_CHARS + 2) begin
        conflict = 1'b1;
      end else if (have_len && len_kept != acc) begin
        conflict = 1'b1;
      end else begin
        len_kept = acc;
        have_len = 1'b1;
      end
    end
    new_line();
  endfunction

  // scans one byte; returns 1 with the report when the byte ends the request
  function automatic bit predict_length(input logic [7:0] c, input bit is_last,
                                        output report_t rpt);
    rpt = '0;
    if (c == CH_LF) begin
      close_line();
    end else if (c != CH_SP) begin
      if (line_col < NAME_CHARS) begin
        if (c != HDR_NAME[line_col]) name_ok = 1'b0;
      end else if (name_ok) begin
        // the newest character stays pending, so the line's last one is dropped
        if (pend_ok) take_digit(pend_ch);
        pend_ch = c;
        pend_ok = 1'b1;
      end
      if (line_col < COL_MAX) line_col++;
    end
    if (!is_last) return 1'b0;
    if (conflict) begin
      rpt.st = ST_BAD;
    end else if (have_len) begin
      rpt.len = len_kept[30:0];
      rpt.st  = ST_OK;
    end else begin
      rpt.st = ST_ABSENT;
    end
    new_request();
    return 1'b1;
  endfunction

  // stimulus helpers
  function automatic logic [7:0] rand_glyph();
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  function automatic void push_text(ref logic [7:0] q[$], input string s, input int sp_pct);
    for (int i = 0; i < s.len(); i++) begin
      if ($urandom_range(99) < sp_pct) q.insert(q.size(), CH_SP);
      q.insert(q.size(), s[i]);
    end
  endfunction

  function automatic string value_digits();
    longint unsigned v;
    string s;
    case ($urandom_range(5))
      0: v = $urandom_range(0, 9);
      1: v = $urandom_range(0, 99999);
      2: v = $urandom;
      3: v = 64'd2147483647 - $urandom_range(0, 3);
      4: v = 64'd2147483648 + $urandom_range(0, 3);
      default: v = {$urandom, $urandom};
    endcase
    s = $sformatf("%0d", v);
    if ($urandom_range(7) == 0) s = {"000", s};
    return s;
  endfunction

  // one request: mostly length lines with random content, some filler and noise
  function automatic void build_request(ref logic [7:0] q[$]);
    string val;
    string name;
    string tail;
    int    n_lines;
    int    k;
    int    sp;
    val = value_digits();
    n_lines = $urandom_range(1, 2);
    for (int ln = 0; ln < n_lines; ln++) begin
      if ($urandom_range(9) < 3) begin
        // filler line, partly raw bytes
        k = $urandom_range(0, 10);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(3) == 0) q.insert(q.size(), 8'($urandom_range(0, 255)));
          else q.insert(q.size(), rand_glyph());
        end
        q.insert(q.size(), CH_LF);
      end else begin
        sp = ($urandom_range(3) == 0) ? 20 : 0;
        name = HDR_NAME;
        case ($urandom_range(15))
          0: name[$urandom_range(NAME_CHARS - 1)] = rand_glyph();
          1: name = name.substr(0, $urandom_range(NAME_CHARS - 2));
          default: ;
        endcase
        // usually repeat the request's value, sometimes a different one
        if ($urandom_range(3) == 0) val = value_digits();
        tail = val;
        case ($urandom_range(15))
          0: tail = "";
          1: tail[$urandom_range(tail.len() - 1)] = rand_glyph();
          default: ;
        endcase
        push_text(q, name, sp);
        if ($urandom_range(1) == 0) q.insert(q.size(), CH_SP);
        push_text(q, tail, sp);
        case ($urandom_range(7))
          0: ;
          1: q.insert(q.size(), 8'($urandom_range(CH_ZERO, CH_NINE)));
          default: q.insert(q.size(), CH_CR);
        endcase
        q.insert(q.size(), CH_LF);
      end
    end
    // trailing fragment without line end
    if ($urandom_range(4) == 0) begin
      k = $urandom_range(1, 6);
      for (int i = 0; i < k; i++) q.insert(q.size(), 8'($urandom_range(0, 255)));
      if (q[q.size() - 1] == CH_LF) q[q.size() - 1] = CH_ZERO;
    end
  endfunction

  function automatic void add_row(input string s, input bit typed, input logic [30:0] len,
                                  input status_t st);
    dir_row_t r;
    r.text = s;
    r.typed = typed;
    r.want.len = len;
    r.want.st = st;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // drive one byte word and wait for it to be taken
  task automatic send_byte(input logic [7:0] b, input bit is_last, input bit typed,
                           input report_t want);
    report_t rpt;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_byte_req <= b;
    in_last     <= is_last;
    do @(posedge clk); while (in_stall);
    if (predict_length(b, is_last, rpt))
      length_reports_due.insert(length_reports_due.size(), typed ? want : rpt);
  endtask

  task automatic send_request(input logic [7:0] q[$], input bit typed, input report_t want);
    for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1, typed, want);
  endtask

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
  endfunction

  // receiver: random stall, with one long hold-off on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (length_reports_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result length %0d status %0d",
                                out_length_value, out_status));
      end else begin
        head_report = length_reports_due.pop_front();
        if (out_length_value !== head_report.len)
          note_mismatch($sformatf("length expected %0d got %0d",
                                  head_report.len, out_length_value));
        if (out_status !== head_report.st)
          note_mismatch($sformatf("status expected %0d got %0d",
                                  head_report.st, out_status));
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    logic [7:0] req[$];
    int sent_bytes;
    int sent_reqs;
    new_request();

    // directed requests; CR is written as octal 015
    add_row("\n", 1, 0, ST_ABSENT);
    add_row("Host: a\015\nContent-Length: 0\015\n\n", 1, 0, ST_OK);
    add_row("Content-Length: 2147483647\015\n\n", 1, 31'd2147483647, ST_OK);
    add_row("Content-Length: 2147483648\015\n\n", 1, 0, ST_BAD);
    add_row("Content-Lengt\015\n\n", 1, 0, ST_ABSENT);
    add_row("Content-Length:\n\n", 1, 0, ST_BAD);
    add_row("Content-Length:\015\n\n", 1, 0, ST_BAD);
    add_row("Content-Length:42\n\n", 0, 0, ST_OK);
    add_row("Content-Length: 1x\015\n\n", 1, 0, ST_BAD);
    add_row("Content-Length: 12\015\nContent-Length: 12\015\n\n", 0, 0, ST_OK);
    add_row("Content-Length: 12\015\nContent-Length: 13\015\n\n", 1, 0, ST_BAD);
    add_row("Content-Length: 5\015\nContent-Length: 7", 0, 0, ST_OK);
    add_row("C o n tent-Length :  9 9 \015\n\n", 0, 0, ST_OK);
    add_row("content-length: 5\015\n\n", 1, 0, ST_ABSENT);
    add_row("Content-Length: 00000000000000000000000031\015\n", 0, 0, ST_OK);
    add_row("Content-Length: x\015\nContent-Length: 8\015\n\n", 1, 0, ST_BAD);
    add_row("Content-Length: 99999999999999999999\015\n\n", 1, 0, ST_BAD);
    add_row("\377X: \001\200\015\nContent-Length: 3\015\n\n", 0, 0, ST_OK);
    add_row("X", 1, 0, ST_ABSENT);
    add_row("Content-Length: 7\015", 1, 0, ST_ABSENT);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      req.delete();
      for (int j = 0; j < directed_rows[i].text.len(); j++)
        req.insert(req.size(), directed_rows[i].text[j]);
      send_request(req, directed_rows[i].typed, directed_rows[i].want);
    end

    // random requests under three idling patterns
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 7;
          stall_pct     = 63;
        end
        1: begin
          send_idle_pct = 63;
          stall_pct     = 7;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          hold_asks++;
        end
      endcase
      sent_bytes = 0;
      sent_reqs  = 0;
      while (sent_bytes < 140 || sent_reqs < 4) begin
        req.delete();
        build_request(req);
        send_request(req, 1'b0, '0);
        sent_bytes += req.size();
        sent_reqs++;
      end
    end
    in_valid <= 1'b0;

    while (length_reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/hcl_pkg.sv
hdl/hcl_scan_step.sv
hdl/http_content_length_scan_core.sv
test/tb_http_content_length_scan_core.sv
